// File: src/ipacl_pkg.sv
// package: item types, codes and helpers of the ipv4 prefix acl with mac rewrite
`timescale 1ns / 1ps
`default_nettype none
package ipacl_pkg;

	localparam int AclEntries = 16;
	localparam int AddrBits   = 32;
	localparam int LenBits    = 6;
	localparam int MacBits    = 48;
	localparam int CfgIdxBits = 1;

	typedef enum logic {
		FUNC_INSTALL = 1'b0,
		FUNC_CHECK   = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_FORWARDED = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_INSTALLED = 3'd2,
		ST_REPLACED  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [CfgIdxBits-1:0] {
		CFG_LEFT_MAC  = 1'b0,
		CFG_RIGHT_MAC = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                func;
		logic [AddrBits-1:0] acl_prefix;
		logic [LenBits-1:0]  acl_length;
		logic [AddrBits-1:0] dest_ip;
		logic                direction;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [MacBits-1:0] new_dest_mac;
	} rsp_t;

	// item travelling along the cell row
	typedef struct packed {
		logic                vld;
		func_t               func;
		logic [AddrBits-1:0] key;
		logic [LenBits-1:0]  len;
		logic                dir;
		logic                match;
		logic                placed;
	} tok_t;

	function automatic logic [AddrBits-1:0] len_mask(input logic [LenBits-1:0] len);
		return ~({AddrBits{1'b1}} >> len);
	endfunction

	function automatic logic [LenBits-1:0] len_sat(input logic [LenBits-1:0] len);
		logic [LenBits-1:0] lim;
		lim = LenBits'(AddrBits);
		return (len > lim) ? lim : len;
	endfunction

endpackage
`default_nettype wire

// File: src/ipv4_prefix_acl_mac_rewrite.sv
// top level: ipv4 drop prefix table as a row of cells with mac rewrite
//
// channel   direction  handshake               payload
// command   in         start & !busy           cmd (ipacl_pkg::cmd_t)
// result    out        done, one cycle strobe  rsp (ipacl_pkg::rsp_t)
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// an item walks the row one cell per cycle; done goes high once it has left the
// last cell and busy falls in that same cycle, so the next item is taken only
// once the last one is done.
// reset empties the table at once and clears both macs.
// the receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_prefix_acl_mac_rewrite #(
	parameter int ACL_ENTRIES = ipacl_pkg::AclEntries
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire ipacl_pkg::cmd_t                    cmd,
	output logic                                    done,
	output ipacl_pkg::rsp_t                         rsp,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ipacl_pkg::CfgIdxBits-1:0]   cfg_index,
	input  wire logic [ipacl_pkg::MacBits-1:0]      cfg_data
);

	logic [ipacl_pkg::MacBits-1:0] left_mac_q;
	logic [ipacl_pkg::MacBits-1:0] right_mac_q;
	logic                          busy_q;
	logic                          done_q;
	ipacl_pkg::rsp_t               rsp_q;
	ipacl_pkg::tok_t               tok [ACL_ENTRIES+1];
	ipacl_pkg::tok_t               tok_head;
	logic [ACL_ENTRIES:0]          tok_vld;
	logic                          accept;
	logic [ipacl_pkg::LenBits-1:0] len_in;
	ipacl_pkg::tok_t               last;
	ipacl_pkg::rsp_t               rsp_nxt;

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;
	assign len_in    = ipacl_pkg::len_sat(cmd.acl_length);

	always_comb begin
		tok_head.vld    = accept;
		tok_head.func   = ipacl_pkg::func_t'(cmd.func);
		tok_head.key    = (cmd.func == ipacl_pkg::FUNC_CHECK) ? cmd.dest_ip
		                  : (cmd.acl_prefix & ipacl_pkg::len_mask(len_in));
		tok_head.len    = len_in;
		tok_head.dir    = cmd.direction;
		tok_head.match  = 1'b0;
		tok_head.placed = 1'b0;
	end

	assign tok[0] = tok_head;

	for (genvar i = 0; i < ACL_ENTRIES; i++) begin : g_cell
		ipacl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	for (genvar i = 0; i <= ACL_ENTRIES; i++) begin : g_vld
		assign tok_vld[i] = tok[i].vld;
	end

	assign last = tok[ACL_ENTRIES];

	always_comb begin
		rsp_nxt.new_dest_mac = '0;
		if (last.func == ipacl_pkg::FUNC_CHECK) begin
			if (last.match) begin
				rsp_nxt.status = ipacl_pkg::ST_DROPPED;
			end else begin
				rsp_nxt.status       = ipacl_pkg::ST_FORWARDED;
				rsp_nxt.new_dest_mac = last.dir ? right_mac_q : left_mac_q;
			end
		end else if (last.match) begin
			rsp_nxt.status = ipacl_pkg::ST_REPLACED;
		end else if (last.placed) begin
			rsp_nxt.status = ipacl_pkg::ST_INSTALLED;
		end else begin
			rsp_nxt.status = ipacl_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			left_mac_q  <= '0;
			right_mac_q <= '0;
		end else begin
			done_q <= last.vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.vld) begin
				busy_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ipacl_pkg::CFG_LEFT_MAC:  left_mac_q  <= cfg_data;
					ipacl_pkg::CFG_RIGHT_MAC: right_mac_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one item in the cell row");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q || done_q)
		else $error("accepted item not tracked");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last.vld |-> busy_q)
		else $error("item left the row while idle");

	a_mac_only_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (rsp_q.status != ipacl_pkg::ST_FORWARDED) |-> rsp_q.new_dest_mac == '0)
		else $error("mac set on a result that is not forwarded");

endmodule
`default_nettype wire

// File: src/ipacl_cell.sv
// cell: one table entry, checks or installs the passing item and hands it on
`timescale 1ns / 1ps
`default_nettype none
module ipacl_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ipacl_pkg::tok_t tok_in,
	output ipacl_pkg::tok_t      tok_out
);

	logic [ipacl_pkg::AddrBits-1:0] pfx_q;
	logic [ipacl_pkg::LenBits-1:0]  len_q;
	logic                           valid_q;
	logic                           vld_q;
	ipacl_pkg::tok_t                tok_q;
	ipacl_pkg::tok_t                tok_nxt;
	logic                           wr_en;
	logic                           same;

	always_comb begin
		tok_nxt = tok_in;
		wr_en   = 1'b0;
		same    = valid_q && (pfx_q == tok_in.key) && (len_q == tok_in.len);
		if (tok_in.func == ipacl_pkg::FUNC_CHECK) begin
			if (valid_q && ((tok_in.key & ipacl_pkg::len_mask(len_q)) == pfx_q)) begin
				tok_nxt.match = 1'b1;
			end
		end else if (!tok_in.match && !tok_in.placed) begin
			// entries fill from the low end, so the first free cell ends the search
			if (same) begin
				tok_nxt.match = 1'b1;
			end else if (!valid_q) begin
				tok_nxt.placed = 1'b1;
				wr_en          = tok_in.vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
			if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (wr_en) begin
			pfx_q <= tok_in.key;
			len_q <= tok_in.len;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

endmodule
`default_nettype wire

// File: tb/sv/tb_ipv4_prefix_acl_mac_rewrite.sv
// testbench: prefix table install and packet filter with mac rewrite, checked against a local predictor
`timescale 1ns / 1ps
module tb_ipv4_prefix_acl_mac_rewrite;
	import ipacl_pkg::*;

	localparam int ACL_ENTRIES = AclEntries;
	localparam int STALL_LIMIT = 2000;
	localparam int FILL_CAP    = ACL_ENTRIES - 1;
	localparam logic [MacBits-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
	localparam logic [MacBits-1:0] MAC_B    = 48'h0123_4567_89AB;

	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	cmd_t                  cmd;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CfgIdxBits-1:0] cfg_index;
	logic [MacBits-1:0]    cfg_data;

	// predictor copy of the table and the macs
	logic [AddrBits-1:0] tbl_prefix [ACL_ENTRIES];
	int                  tbl_len [ACL_ENTRIES];
	bit                  tbl_used [ACL_ENTRIES];
	int                  tbl_count;
	logic [MacBits-1:0]  mac_left;
	logic [MacBits-1:0]  mac_right;

	rsp_t      expected_verdicts [$];
	stim_row_t rows [$];
	rsp_t      want_rsp;
	int        head_rows;
	int        mismatch_count;
	int        stall_cnt;
	bit        idle_on;

	ipv4_prefix_acl_mac_rewrite dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [AddrBits-1:0] cover_mask(input int n);
		logic [AddrBits-1:0] m;
		m = '1;
		return m << (AddrBits - n);
	endfunction

	function automatic rsp_t filter_verdict(input cmd_t c);
		rsp_t r;
		int i;
		int n;
		int free_slot;
		bit hit;
		logic [AddrBits-1:0] key;
		r.status = ST_FORWARDED;
		r.new_dest_mac = '0;
		free_slot = -1;
		hit = 1'b0;
		if (c.func == FUNC_INSTALL) begin
			n = (c.acl_length > AddrBits) ? AddrBits : int'(c.acl_length);
			key = c.acl_prefix & cover_mask(n);
			for (i = 0; i < ACL_ENTRIES; i++) begin
				if (tbl_used[i]) begin
					if (tbl_prefix[i] == key && tbl_len[i] == n)
						hit = 1'b1;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit) begin
				r.status = ST_REPLACED;
			end else if (free_slot < 0) begin
				r.status = ST_FULL;
			end else begin
				tbl_prefix[free_slot] = key;
				tbl_len[free_slot] = n;
				tbl_used[free_slot] = 1'b1;
				tbl_count++;
				r.status = ST_INSTALLED;
			end
		end else begin
			for (i = 0; i < ACL_ENTRIES; i++)
				if (tbl_used[i] && (c.dest_ip & cover_mask(tbl_len[i])) == tbl_prefix[i])
					hit = 1'b1;
			if (hit)
				r.status = ST_DROPPED;
			else
				r.new_dest_mac = c.direction ? mac_right : mac_left;
		end
		return r;
	endfunction

	function automatic int pick_used();
		int i;
		int k;
		if (tbl_count == 0)
			return -1;
		k = $urandom_range(0, tbl_count - 1);
		for (i = 0; i < ACL_ENTRIES; i++) begin
			if (tbl_used[i]) begin
				if (k == 0)
					return i;
				k--;
			end
		end
		return -1;
	endfunction

	// about half of the items aim at stored prefixes so both hits and near misses show up
	function automatic cmd_t random_item(input bit capped);
		cmd_t c;
		int slot;
		logic [AddrBits-1:0] m;
		c.func = ($urandom_range(0, 5) == 0) ? FUNC_INSTALL : FUNC_CHECK;
		c.acl_prefix = $urandom;
		c.acl_length = 6'($urandom_range(0, 63));
		c.dest_ip = $urandom;
		c.direction = 1'($urandom);
		slot = pick_used();
		if (c.func == FUNC_INSTALL) begin
			if (slot >= 0 && ($urandom_range(0, 1) == 0 || (capped && tbl_count >= FILL_CAP))) begin
				m = cover_mask(tbl_len[slot]);
				c.acl_prefix = tbl_prefix[slot] | (c.acl_prefix & ~m);
				if (tbl_len[slot] == AddrBits && $urandom_range(0, 1) == 1)
					c.acl_length = 6'($urandom_range(33, 63));
				else
					c.acl_length = 6'(tbl_len[slot]);
			end else begin
				case ($urandom_range(0, 7))
					0: begin
						c.acl_length = 6'($urandom_range(3, 7));
					end
					1: begin
						c.acl_length = 6'($urandom_range(33, 63));
					end
					default: begin
						c.acl_length = 6'($urandom_range(8, 32));
					end
				endcase
			end
		end else if (slot >= 0 && $urandom_range(0, 1) == 1) begin
			m = cover_mask(tbl_len[slot]);
			c.dest_ip = tbl_prefix[slot] | (c.dest_ip & ~m);
			if (tbl_len[slot] > 0 && $urandom_range(0, 2) == 0) begin
				slot = AddrBits - 1 - $urandom_range(0, tbl_len[slot] - 1);
				c.dest_ip[slot] = ~c.dest_ip[slot];
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic add_row(input func_t f, input logic [AddrBits-1:0] pfx,
			input logic [LenBits-1:0] len, input logic [AddrBits-1:0] dst, input logic dir,
			input bit typed, input status_t st, input logic [MacBits-1:0] mac);
		stim_row_t r;
		r.c.func = f;
		r.c.acl_prefix = pfx;
		r.c.acl_length = len;
		r.c.dest_ip = dst;
		r.c.direction = dir;
		r.typed = typed;
		r.want.status = st;
		r.want.new_dest_mac = mac;
		rows.push_back(r);
	endtask

	task automatic send_item(input cmd_t c, input bit typed, input rsp_t want);
		rsp_t predicted;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		predicted = filter_verdict(c);
		expected_verdicts.push_back(typed ? want : predicted);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic run_rows(input int lo, input int hi);
		int k;
		for (k = lo; k < hi; k++)
			send_item(rows[k].c, rows[k].typed, rows[k].want);
	endtask

	task automatic run_random(input int n, input bit capped);
		int k;
		rsp_t none;
		none = '0;
		for (k = 0; k < n; k++)
			send_item(random_item(capped), 1'b0, none);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_macs(input logic [MacBits-1:0] l, input logic [MacBits-1:0] r);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_LEFT_MAC;
		cfg_data <= l;
		do @(posedge clk); while (!cfg_ready);
		mac_left = l;
		cfg_index <= CFG_RIGHT_MAC;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		mac_right = r;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("result with no item pending", 64'(rsp), 64'(0));
			end else begin
				want_rsp = expected_verdicts.pop_front();
				if (rsp.status !== want_rsp.status)
					report_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
				if (rsp.new_dest_mac !== want_rsp.new_dest_mac)
					report_mismatch("new_dest_mac", 64'(rsp.new_dest_mac),
						64'(want_rsp.new_dest_mac));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int p;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_LEFT_MAC;
		cfg_data <= '0;
		mismatch_count = 0;
		stall_cnt = 0;
		idle_on = 1'b1;
		tbl_count = 0;
		mac_left = '0;
		mac_right = '0;
		for (p = 0; p < ACL_ENTRIES; p++) begin
			tbl_prefix[p] = '0;
			tbl_len[p] = 0;
			tbl_used[p] = 1'b0;
		end

		// macs still at reset value for the first row
		add_row(FUNC_CHECK, 32'hDEAD_BEEF, 6'd63, 32'h0000_0000, 1'b1, 1, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'hFFFF_FFFF, 1'b0, 1, ST_FORWARDED, MAC_ONES);
		add_row(FUNC_CHECK, 32'hFFFF_FFFF, 6'd32, 32'h0, 1'b1, 1, ST_FORWARDED, MAC_B);
		add_row(FUNC_INSTALL, 32'hFFFF_FFFF, 6'd32, 32'h0, 1'b0, 1, ST_INSTALLED, '0);
		add_row(FUNC_INSTALL, 32'hFFFF_FFFF, 6'd32, 32'h0, 1'b1, 1, ST_REPLACED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'hFFFF_FFFF, 1'b1, 1, ST_DROPPED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'hFFFF_FFFE, 1'b1, 1, ST_FORWARDED, MAC_B);
		add_row(FUNC_INSTALL, 32'h0A0B_0C0D, 6'd8, 32'h0, 1'b0, 1, ST_INSTALLED, '0);
		// bits past the length are masked off, so this matches the entry above
		add_row(FUNC_INSTALL, 32'h0AFF_FFFF, 6'd8, 32'h0, 1'b0, 1, ST_REPLACED, '0);
		add_row(FUNC_INSTALL, 32'h0A80_0000, 6'd9, 32'h0, 1'b0, 1, ST_INSTALLED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'h0A12_3456, 1'b0, 1, ST_DROPPED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'h0B00_0000, 1'b0, 0, ST_FORWARDED, '0);
		// lengths above 32 saturate
		add_row(FUNC_INSTALL, 32'h1234_5678, 6'd63, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_INSTALL, 32'h1234_5678, 6'd32, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_INSTALL, 32'h1234_5678, 6'd33, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'h1234_5678, 1'b1, 0, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'h1234_5679, 1'b0, 0, ST_FORWARDED, '0);
		head_rows = rows.size();
		// zero length covers every address and fills the last slot, so it runs after the capped random runs
		add_row(FUNC_INSTALL, 32'hDEAD_BEEF, 6'd0, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_INSTALL, 32'h0000_0000, 6'd0, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_INSTALL, 32'h1357_2468, 6'd20, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_INSTALL, 32'hFFFF_FFFF, 6'd40, 32'h0, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'h0000_0000, 1'b0, 0, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'hFFFF_FFFF, 1'b1, 0, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'h55AA_55AA, 1'b1, 0, ST_FORWARDED, '0);
		add_row(FUNC_CHECK, 32'h0, 6'd0, 32'hAA55_AA55, 1'b0, 0, ST_FORWARDED, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		run_rows(0, 1);
		settle();
		set_macs(MAC_ONES, MAC_B);
		run_rows(1, head_rows);

		for (p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					set_macs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
				end
				1: begin
					set_macs('0, MAC_ONES);
				end
				2: begin
					set_macs(MAC_ONES, '0);
				end
				default: begin
					set_macs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
				end
			endcase
			// no idling in the last part of the run
			idle_on = (p < 3);
			run_random(300, 1'b1);
		end
		run_rows(head_rows, rows.size());
		run_random(60, 1'b0);

		settle();
		repeat (ACL_ENTRIES + 4) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch("results never arrived", 64'(expected_verdicts.size()), 64'(0));
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
